// ----- sv/qalu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package qalu_pkg;

    // Component format: signed fixed point, FRAC_BITS fraction bits
    localparam int COMP_WIDTH = 16;
    localparam int FRAC_BITS  = 12;

    // Full product width and width of the four-term sum
    localparam int PROD_WIDTH = 2 * COMP_WIDTH;
    localparam int SUM_WIDTH  = PROD_WIDTH + 2;

    // Action codes
    localparam logic [2:0] ACT_ADD   = 3'd0;
    localparam logic [2:0] ACT_SUB   = 3'd1;
    localparam logic [2:0] ACT_MUL   = 3'd2;
    localparam logic [2:0] ACT_SCALE = 3'd3;
    localparam logic [2:0] ACT_CONJ  = 3'd4;
    localparam logic [2:0] ACT_NEG   = 3'd5;

    // Hamilton product: term k of component c uses b[c ^ k]; bit (4*c + k) set
    // means the term is subtracted
    localparam logic [15:0] HAM_NEG = 16'h428E;

    // Rounding offset and clip limits, at sum width plus one
    localparam logic signed [SUM_WIDTH:0] RND_HALF =
        (SUM_WIDTH + 1)'(1) << (FRAC_BITS - 1);
    localparam logic signed [SUM_WIDTH:0] SAT_MAX =
        (SUM_WIDTH + 1)'((64'd1 << (COMP_WIDTH - 1)) - 64'd1);
    localparam logic signed [SUM_WIDTH:0] SAT_MIN = ~SAT_MAX;

    typedef struct packed {
        logic [2:0]                   action;
        logic signed [COMP_WIDTH-1:0] a_w;
        logic signed [COMP_WIDTH-1:0] a_x;
        logic signed [COMP_WIDTH-1:0] a_y;
        logic signed [COMP_WIDTH-1:0] a_z;
        logic signed [COMP_WIDTH-1:0] b_w;
        logic signed [COMP_WIDTH-1:0] b_x;
        logic signed [COMP_WIDTH-1:0] b_y;
        logic signed [COMP_WIDTH-1:0] b_z;
        logic signed [COMP_WIDTH-1:0] scale;
    } in_t;

    typedef struct packed {
        logic signed [COMP_WIDTH-1:0] r_w;
        logic signed [COMP_WIDTH-1:0] r_x;
        logic signed [COMP_WIDTH-1:0] r_y;
        logic signed [COMP_WIDTH-1:0] r_z;
        logic                         saturated;
    } out_t;

    // Multiplier stage result: 16 raw products, their signs, and the
    // unscaled linear value per component for the non-product actions
    typedef struct packed {
        logic [3:0][3:0][PROD_WIDTH-1:0] prod;
        logic [3:0][3:0]                 neg;
        logic [3:0][COMP_WIDTH:0]        lin;
        logic                            use_prod;
    } mul_data_t;

    // Adder stage result: exact sum per component, scaled by 2^FRAC_BITS
    typedef struct packed {
        logic [3:0][SUM_WIDTH-1:0] acc;
        logic                      use_prod;
    } sum_data_t;

endpackage

`default_nettype wire

// ----- sv/qalu_mul_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module qalu_mul_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output      logic              in_ready,
    input  wire qalu_pkg::in_t     in_data,
    output      logic              out_valid,
    input  wire logic              out_ready,
    output      qalu_pkg::mul_data_t out_data
);

    logic                  valid_reg;
    qalu_pkg::mul_data_t   data_reg;
    qalu_pkg::mul_data_t   data_next;

    logic signed [qalu_pkg::COMP_WIDTH-1:0] a_vec [4];
    logic signed [qalu_pkg::COMP_WIDTH-1:0] b_vec [4];

    // Unpack operands into indexable form
    always_comb begin
        a_vec[0] = in_data.a_w;
        a_vec[1] = in_data.a_x;
        a_vec[2] = in_data.a_y;
        a_vec[3] = in_data.a_z;
        b_vec[0] = in_data.b_w;
        b_vec[1] = in_data.b_x;
        b_vec[2] = in_data.b_y;
        b_vec[3] = in_data.b_z;
    end

    // Route operands into the 4x4 multiplier array and form linear terms
    always_comb begin
        logic signed [qalu_pkg::COMP_WIDTH-1:0] x_op;
        logic signed [qalu_pkg::COMP_WIDTH-1:0] y_op;
        logic signed [qalu_pkg::PROD_WIDTH-1:0] p;
        logic signed [qalu_pkg::COMP_WIDTH:0]   ae;
        logic signed [qalu_pkg::COMP_WIDTH:0]   be;
        logic signed [qalu_pkg::COMP_WIDTH:0]   lv;
        data_next = '0;
        data_next.use_prod = (in_data.action == qalu_pkg::ACT_MUL) ||
                             (in_data.action == qalu_pkg::ACT_SCALE);
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                x_op = '0;
                y_op = '0;
                case (in_data.action)
                    qalu_pkg::ACT_MUL: begin
                        x_op = a_vec[k];
                        y_op = b_vec[c ^ k];
                        data_next.neg[c][k] = qalu_pkg::HAM_NEG[4 * c + k];
                    end
                    qalu_pkg::ACT_SCALE: begin
                        x_op = (c == k) ? a_vec[k] : '0;
                        y_op = in_data.scale;
                    end
                    default: begin
                        x_op = '0;
                        y_op = '0;
                    end
                endcase
                p = x_op * y_op;
                data_next.prod[c][k] = p;
            end

            ae = {a_vec[c][qalu_pkg::COMP_WIDTH-1], a_vec[c]};
            be = {b_vec[c][qalu_pkg::COMP_WIDTH-1], b_vec[c]};
            case (in_data.action)
                qalu_pkg::ACT_ADD:  lv = ae + be;
                qalu_pkg::ACT_SUB:  lv = ae - be;
                qalu_pkg::ACT_CONJ: lv = (c == 0) ? ae : -ae;
                qalu_pkg::ACT_NEG:  lv = -ae;
                default:            lv = '0;
            endcase
            data_next.lin[c] = lv;
        end
    end

    // Advance when the next stage can take the request
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Linear actions must leave the multiplier array idle
    a_lin_no_prod: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !data_reg.use_prod |-> data_reg.prod == '0)
        else $error("product term present on a linear action");

endmodule

`default_nettype wire

// ----- sv/qalu_sum_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module qalu_sum_stage (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output      logic                in_ready,
    input  wire qalu_pkg::mul_data_t in_data,
    output      logic                out_valid,
    input  wire logic                out_ready,
    output      qalu_pkg::sum_data_t out_data
);

    logic                valid_reg;
    qalu_pkg::sum_data_t data_reg;
    qalu_pkg::sum_data_t data_next;

    // Add four signed products per component, or place the linear value
    // at the product scale
    always_comb begin
        logic signed [qalu_pkg::SUM_WIDTH-1:0] t;
        logic signed [qalu_pkg::SUM_WIDTH-1:0] s;
        data_next = '0;
        data_next.use_prod = in_data.use_prod;
        for (int c = 0; c < 4; c++) begin
            s = '0;
            if (in_data.use_prod) begin
                for (int k = 0; k < 4; k++) begin
                    t = $signed(in_data.prod[c][k]);
                    if (in_data.neg[c][k]) begin
                        t = -t;
                    end
                    s = s + t;
                end
            end else begin
                t = $signed(in_data.lin[c]);
                s = t <<< qalu_pkg::FRAC_BITS;
            end
            data_next.acc[c] = s;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Linear values enter at exact multiples of one, so rounding is a no-op
    a_lin_exact: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !data_reg.use_prod |->
            data_reg.acc[0][qalu_pkg::FRAC_BITS-1:0] == '0 &&
            data_reg.acc[1][qalu_pkg::FRAC_BITS-1:0] == '0 &&
            data_reg.acc[2][qalu_pkg::FRAC_BITS-1:0] == '0 &&
            data_reg.acc[3][qalu_pkg::FRAC_BITS-1:0] == '0)
        else $error("fraction bits set on a linear sum");

endmodule

`default_nettype wire

// ----- sv/qalu_sat_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module qalu_sat_stage (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output      logic                in_ready,
    input  wire qalu_pkg::sum_data_t in_data,
    output      logic                out_valid,
    input  wire logic                out_ready,
    output      qalu_pkg::out_t      out_data
);

    localparam int CW = qalu_pkg::COMP_WIDTH;

    logic           valid_reg;
    qalu_pkg::out_t data_reg;
    qalu_pkg::out_t data_next;

    logic signed [CW-1:0] r_vec [4];
    logic [3:0]           clip_vec;

    // Round to nearest (ties up), then clip each component to range
    always_comb begin
        logic signed [qalu_pkg::SUM_WIDTH:0] rnd;
        logic signed [qalu_pkg::SUM_WIDTH:0] q;
        for (int c = 0; c < 4; c++) begin
            rnd = $signed(in_data.acc[c]);
            rnd = rnd + qalu_pkg::RND_HALF;
            q   = rnd >>> qalu_pkg::FRAC_BITS;
            if (q > qalu_pkg::SAT_MAX) begin
                r_vec[c]    = qalu_pkg::SAT_MAX[CW-1:0];
                clip_vec[c] = 1'b1;
            end else if (q < qalu_pkg::SAT_MIN) begin
                r_vec[c]    = qalu_pkg::SAT_MIN[CW-1:0];
                clip_vec[c] = 1'b1;
            end else begin
                r_vec[c]    = q[CW-1:0];
                clip_vec[c] = 1'b0;
            end
        end
        data_next.r_w       = r_vec[0];
        data_next.r_x       = r_vec[1];
        data_next.r_y       = r_vec[2];
        data_next.r_z       = r_vec[3];
        data_next.saturated = |clip_vec;
    end

    // Output register: hold the result until the consumer takes it
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // A clipped result must show a limit code in some component
    a_sat_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && data_reg.saturated |->
            data_reg.r_w == qalu_pkg::SAT_MAX[CW-1:0] ||
            data_reg.r_w == qalu_pkg::SAT_MIN[CW-1:0] ||
            data_reg.r_x == qalu_pkg::SAT_MAX[CW-1:0] ||
            data_reg.r_x == qalu_pkg::SAT_MIN[CW-1:0] ||
            data_reg.r_y == qalu_pkg::SAT_MAX[CW-1:0] ||
            data_reg.r_y == qalu_pkg::SAT_MIN[CW-1:0] ||
            data_reg.r_z == qalu_pkg::SAT_MAX[CW-1:0] ||
            data_reg.r_z == qalu_pkg::SAT_MIN[CW-1:0])
        else $error("saturated flag without a limit code");

endmodule

`default_nettype wire

// ----- sv/quaternion_alu_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Fixed-point quaternion ALU: add, subtract, Hamilton product, scale by a
// scalar, conjugate and negate on signed Q3.12 components. Products are
// summed exactly, rounded to nearest with ties toward plus infinity, and any
// component out of range is clipped with the saturated flag raised; action
// codes 6 and 7 return zero. The block accepts one request per clock cycle
// while the output is not stalled. Each request passes three register stages:
// the 4x4 multiplier array, the four-term adder, and the round/saturate stage,
// whose register is the output and drives m_valid/m_data. Back pressure from
// the output reaches the input through a combinational chain of ready signals.
// A stage that is empty keeps taking data, so bubbles close up. No data is
// dropped or repeated.
module quaternion_alu_top (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output      logic           s_ready,
    input  wire qalu_pkg::in_t  s_data,
    output      logic           m_valid,
    input  wire logic           m_ready,
    output      qalu_pkg::out_t m_data
);

    logic                mul_valid;
    logic                mul_ready;
    qalu_pkg::mul_data_t mul_data;
    logic                sum_valid;
    logic                sum_ready;
    qalu_pkg::sum_data_t sum_data;

    // Stage 1: multiplier array and linear terms
    qalu_mul_stage u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (mul_valid),
        .out_ready (mul_ready),
        .out_data  (mul_data)
    );

    // Stage 2: signed four-term sum
    qalu_sum_stage u_sum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mul_valid),
        .in_ready  (mul_ready),
        .in_data   (mul_data),
        .out_valid (sum_valid),
        .out_ready (sum_ready),
        .out_data  (sum_data)
    );

    // Stage 3: round, saturate, output register
    qalu_sat_stage u_sat (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sum_valid),
        .in_ready  (sum_ready),
        .in_data   (sum_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

    // The pipeline refuses requests only when it is full and the output stalls
    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready && sum_valid && mul_valid)
        else $error("input stalled while pipeline has room");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import qalu_pkg::*;

    // Spare action codes: the block returns zero for these
    localparam logic [2:0] ACT_RSVD6 = 3'd6;
    localparam logic [2:0] ACT_RSVD7 = 3'd7;

    localparam longint COMP_MAX = (longint'(1) <<< (COMP_WIDTH - 1)) - 1;
    localparam longint COMP_MIN = -COMP_MAX - 1;
    localparam longint RND_OFS  = longint'(1) <<< (FRAC_BITS - 1);
    localparam int     Q_ONE    = 1 << FRAC_BITS;
    localparam int     MAX_I    = 32767;
    localparam int     MIN_I    = -32768;
    localparam int     RANDOM_REQS = 750;
    localparam int     DRAIN_CYCLES = 12;

    logic   aclk    = 1'b0;
    logic   aresetn = 1'b0;
    logic   s_valid = 1'b0;
    logic   s_ready;
    in_t    s_data  = '0;
    logic   m_valid;
    logic   m_ready = 1'b0;
    out_t   m_data;

    in_t    pending_q[$];
    out_t   result_q[$];
    int     total_reqs = 0;
    int     accept_cnt = 0;
    int     check_cnt  = 0;
    int     sat_cnt    = 0;
    int     err_cnt    = 0;
    int     act_cnt[8] = '{default: 0};
    int     gap_cnt    = 0;
    int     drv_calm   = 0;
    int     stall_cnt  = 0;
    int     mon_calm   = 0;

    quaternion_alu_top uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // Clip one component to the signed range, flag if clipped
    function automatic logic signed [COMP_WIDTH-1:0] clamp_comp(input longint v,
                                                                inout logic sat);
        if (v > COMP_MAX) begin
            sat = 1'b1;
            return COMP_MAX[COMP_WIDTH-1:0];
        end
        if (v < COMP_MIN) begin
            sat = 1'b1;
            return COMP_MIN[COMP_WIDTH-1:0];
        end
        return v[COMP_WIDTH-1:0];
    endfunction

    // Round an exact product sum to nearest (ties up), then clip
    function automatic logic signed [COMP_WIDTH-1:0] round_comp(input longint acc,
                                                                inout logic sat);
        return clamp_comp((acc + RND_OFS) >>> FRAC_BITS, sat);
    endfunction

    // Expected quaternion result for one request
    function automatic out_t quat_result(input in_t req);
        longint a[4];
        longint b[4];
        longint sc;
        logic   sat;
        out_t   res;
        a[0] = req.a_w; a[1] = req.a_x; a[2] = req.a_y; a[3] = req.a_z;
        b[0] = req.b_w; b[1] = req.b_x; b[2] = req.b_y; b[3] = req.b_z;
        sc   = req.scale;
        sat  = 1'b0;
        res  = '0;
        case (req.action)
            ACT_ADD: begin
                res.r_w = clamp_comp(a[0] + b[0], sat);
                res.r_x = clamp_comp(a[1] + b[1], sat);
                res.r_y = clamp_comp(a[2] + b[2], sat);
                res.r_z = clamp_comp(a[3] + b[3], sat);
            end
            ACT_SUB: begin
                res.r_w = clamp_comp(a[0] - b[0], sat);
                res.r_x = clamp_comp(a[1] - b[1], sat);
                res.r_y = clamp_comp(a[2] - b[2], sat);
                res.r_z = clamp_comp(a[3] - b[3], sat);
            end
            ACT_MUL: begin
                res.r_w = round_comp(a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3], sat);
                res.r_x = round_comp(a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2], sat);
                res.r_y = round_comp(a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1], sat);
                res.r_z = round_comp(a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0], sat);
            end
            ACT_SCALE: begin
                res.r_w = round_comp(a[0] * sc, sat);
                res.r_x = round_comp(a[1] * sc, sat);
                res.r_y = round_comp(a[2] * sc, sat);
                res.r_z = round_comp(a[3] * sc, sat);
            end
            ACT_CONJ: begin
                res.r_w = req.a_w;
                res.r_x = clamp_comp(-a[1], sat);
                res.r_y = clamp_comp(-a[2], sat);
                res.r_z = clamp_comp(-a[3], sat);
            end
            ACT_NEG: begin
                res.r_w = clamp_comp(-a[0], sat);
                res.r_x = clamp_comp(-a[1], sat);
                res.r_y = clamp_comp(-a[2], sat);
                res.r_z = clamp_comp(-a[3], sat);
            end
            default: ;
        endcase
        res.saturated = sat;
        return res;
    endfunction

    function automatic in_t make_req(input logic [2:0] act,
                                     input int aw, input int ax, input int ay, input int az,
                                     input int bw, input int bx, input int by, input int bz,
                                     input int sc);
        in_t req;
        req.action = act;
        req.a_w = aw[COMP_WIDTH-1:0]; req.a_x = ax[COMP_WIDTH-1:0];
        req.a_y = ay[COMP_WIDTH-1:0]; req.a_z = az[COMP_WIDTH-1:0];
        req.b_w = bw[COMP_WIDTH-1:0]; req.b_x = bx[COMP_WIDTH-1:0];
        req.b_y = by[COMP_WIDTH-1:0]; req.b_z = bz[COMP_WIDTH-1:0];
        req.scale = sc[COMP_WIDTH-1:0];
        return req;
    endfunction

    // Component value: mostly within +/-2.0, sometimes any code or an extreme
    function automatic int rand_comp();
        case ($urandom_range(0, 9))
            0:       return MAX_I;
            1:       return MIN_I;
            2, 3, 4: return int'($urandom_range(0, 65535)) - 32768;
            default: return int'($urandom_range(0, 2 * (2 * Q_ONE))) - 2 * Q_ONE;
        endcase
    endfunction

    // Idle length: mostly none, some short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void check_comp(input string name,
                                       input logic signed [COMP_WIDTH-1:0] exp_v,
                                       input logic signed [COMP_WIDTH-1:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            err_cnt++;
        end
    endfunction

    // Driver: present pending requests, record expectations on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                result_q.push_back(quat_result(s_data));
                act_cnt[s_data.action]++;
                accept_cnt++;
            end
            if (!s_valid || s_ready) begin
                if (gap_cnt > 0) begin
                    gap_cnt--;
                    s_valid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    s_data  <= pending_q.pop_front();
                    s_valid <= 1'b1;
                    if (drv_calm > 0) begin
                        drv_calm--;
                    end else begin
                        gap_cnt = idle_len();
                        if ($urandom_range(0, 39) == 0)
                            drv_calm = $urandom_range(20, 60);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall at random, compare each result with the oldest expectation
    always @(posedge aclk) begin
        out_t exp_r;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    $error("unexpected result: %p", m_data);
                    err_cnt++;
                end else begin
                    exp_r = result_q.pop_front();
                    check_comp("r_w", exp_r.r_w, m_data.r_w);
                    check_comp("r_x", exp_r.r_x, m_data.r_x);
                    check_comp("r_y", exp_r.r_y, m_data.r_y);
                    check_comp("r_z", exp_r.r_z, m_data.r_z);
                    if (m_data.saturated !== exp_r.saturated) begin
                        $error("saturated: expected %0d, got %0d",
                               exp_r.saturated, m_data.saturated);
                        err_cnt++;
                    end
                    if (exp_r.saturated)
                        sat_cnt++;
                    check_cnt++;
                end
            end
            // Hold ready low for the rest of a stall, else pick the next one
            if (stall_cnt > 0) begin
                stall_cnt--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (mon_calm > 0) begin
                    mon_calm--;
                end else begin
                    stall_cnt = idle_len();
                    if ($urandom_range(0, 39) == 0)
                        mon_calm = $urandom_range(20, 60);
                end
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int i;
        logic [2:0] act;
        // Directed: overflow on every action, rounding ties, spare codes
        pending_q.push_back(make_req(ACT_ADD, 0, 0, 0, 0, 0, 0, 0, 0, rand_comp()));
        pending_q.push_back(make_req(ACT_ADD, MAX_I, MAX_I, 1, MAX_I,
                                     MAX_I, 1, MAX_I, 0, 0));
        pending_q.push_back(make_req(ACT_ADD, MIN_I, MIN_I, -1, 0,
                                     MIN_I, -1, MIN_I, MIN_I, 0));
        pending_q.push_back(make_req(ACT_ADD, MAX_I, 6144, -1000, 3,
                                     MIN_I, 1024, 1000, -7, MAX_I));
        pending_q.push_back(make_req(ACT_SUB, MAX_I, MAX_I, 0, -1,
                                     MIN_I, -1, MIN_I, MAX_I, 0));
        pending_q.push_back(make_req(ACT_SUB, MIN_I, MIN_I, MAX_I, 0,
                                     MAX_I, 1, MIN_I, MAX_I, 0));
        pending_q.push_back(make_req(ACT_SUB, 5000, -3, 77, Q_ONE,
                                     -2000, 3, 77, Q_ONE, MIN_I));
        pending_q.push_back(make_req(ACT_MUL, Q_ONE, 0, 0, 0,
                                     1234, -5678, 910, -1112, 0));
        pending_q.push_back(make_req(ACT_MUL, 0, Q_ONE, 0, 0, 0, 0, Q_ONE, 0, 0));
        pending_q.push_back(make_req(ACT_MUL, MAX_I, MAX_I, MAX_I, MAX_I,
                                     MAX_I, MAX_I, MAX_I, MAX_I, 0));
        pending_q.push_back(make_req(ACT_MUL, MIN_I, MIN_I, MIN_I, MIN_I,
                                     MIN_I, MIN_I, MIN_I, MIN_I, 0));
        pending_q.push_back(make_req(ACT_MUL, MAX_I, MAX_I, MAX_I, MAX_I,
                                     MIN_I, MIN_I, MIN_I, MIN_I, 0));
        pending_q.push_back(make_req(ACT_MUL, MIN_I, MAX_I, MIN_I, MAX_I,
                                     MAX_I, MIN_I, MAX_I, MIN_I, MAX_I));
        pending_q.push_back(make_req(ACT_MUL, 1, 0, 0, 0, Q_ONE / 2, 0, 0, 0, 0));
        pending_q.push_back(make_req(ACT_MUL, -1, 0, 0, 0, Q_ONE / 2, 0, 0, 0, 0));
        pending_q.push_back(make_req(ACT_SCALE, 2000, -3000, 4095, -4096,
                                     MAX_I, MIN_I, MAX_I, MIN_I, Q_ONE));
        pending_q.push_back(make_req(ACT_SCALE, MAX_I, MIN_I, MAX_I, 0,
                                     0, 0, 0, 0, MAX_I));
        pending_q.push_back(make_req(ACT_SCALE, MIN_I, MAX_I, 1, MIN_I,
                                     0, 0, 0, 0, MIN_I));
        pending_q.push_back(make_req(ACT_SCALE, 1, -1, 3, -3,
                                     0, 0, 0, 0, Q_ONE / 2));
        pending_q.push_back(make_req(ACT_CONJ, MIN_I, MIN_I, MAX_I, 0,
                                     MAX_I, MAX_I, MAX_I, MAX_I, MAX_I));
        pending_q.push_back(make_req(ACT_CONJ, 4096, -123, 456, -789,
                                     MIN_I, MIN_I, MIN_I, MIN_I, MIN_I));
        pending_q.push_back(make_req(ACT_NEG, MIN_I, MIN_I, MIN_I, MIN_I,
                                     1, 2, 3, 4, 5));
        pending_q.push_back(make_req(ACT_NEG, MAX_I, MAX_I, 0, -1,
                                     -1, -1, -1, -1, -1));
        pending_q.push_back(make_req(ACT_RSVD6, rand_comp(), MAX_I, MIN_I, rand_comp(),
                                     rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                                     rand_comp()));
        pending_q.push_back(make_req(ACT_RSVD7, MIN_I, rand_comp(), rand_comp(), MAX_I,
                                     rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                                     rand_comp()));

        // Random: valid actions with mixed operand ranges, a few spare codes
        for (i = 0; i < RANDOM_REQS; i++) begin
            if ($urandom_range(0, 99) < 95)
                act = 3'($urandom_range(ACT_ADD, ACT_NEG));
            else
                act = 3'($urandom_range(ACT_RSVD6, ACT_RSVD7));
            pending_q.push_back(make_req(act, rand_comp(), rand_comp(), rand_comp(),
                                         rand_comp(), rand_comp(), rand_comp(),
                                         rand_comp(), rand_comp(), rand_comp()));
        end
        total_reqs = pending_q.size();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Drain: all requests accepted, all results back, then a final idle wait
        while (accept_cnt != total_reqs || result_q.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Requests: add %0d, sub %0d, product %0d, scale %0d, conj %0d, neg %0d, spare %0d",
                 act_cnt[ACT_ADD], act_cnt[ACT_SUB], act_cnt[ACT_MUL], act_cnt[ACT_SCALE],
                 act_cnt[ACT_CONJ], act_cnt[ACT_NEG],
                 act_cnt[ACT_RSVD6] + act_cnt[ACT_RSVD7]);
        $display("Results checked: %0d, %0d of them saturated, %0d mismatches",
                 check_cnt, sat_cnt, err_cnt);
        if (err_cnt == 0 && result_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/qalu_pkg.sv
sv/qalu_mul_stage.sv
sv/qalu_sum_stage.sv
sv/qalu_sat_stage.sv
sv/quaternion_alu_top.sv
tb/testbench.sv
